[rtl/grs512_pkg.sv]
// Groestl-512 shared types, constants and round functions.
package grs512_pkg;

  localparam int Rows = 8;
  localparam int Cols = 16;
  localparam int Rounds = 14;

  typedef logic [7:0] byte_t;
  typedef byte_t [Rows-1:0][Cols-1:0] state_t;

  localparam byte_t SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam int ShiftP [Rows] = '{0, 1, 2, 3, 4, 5, 6, 11};
  localparam int ShiftQ [Rows] = '{1, 3, 5, 11, 0, 2, 4, 6};
  localparam int MixCoef [Rows] = '{2, 2, 3, 4, 5, 3, 5, 7};

  function automatic byte_t gf_x2(byte_t x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic byte_t gf_mul(byte_t x, int c);
    byte_t x2;
    byte_t x4;
    byte_t r;
    x2 = gf_x2(x);
    x4 = gf_x2(x2);
    r = 8'h00;
    if (c[0]) r ^= x;
    if (c[1]) r ^= x2;
    if (c[2]) r ^= x4;
    return r;
  endfunction

  function automatic state_t round_f(state_t s, logic is_q, logic [3:0] rnd);
    state_t a;
    state_t t;
    state_t o;
    byte_t acc;
    a = s;
    for (int c = 0; c < Cols; c++) begin
      if (is_q) begin
        for (int r = 0; r < Rows - 1; r++) a[r][c] ^= 8'hff;
        a[Rows-1][c] ^= 8'hff ^ {c[3:0], 4'h0} ^ {4'h0, rnd};
      end else begin
        a[0][c] ^= {c[3:0], 4'h0} ^ {4'h0, rnd};
      end
    end
    for (int r = 0; r < Rows; r++) begin
      for (int c = 0; c < Cols; c++) begin
        t[r][c] = is_q ? SBOX[a[r][(c + ShiftQ[r]) % Cols]]
                       : SBOX[a[r][(c + ShiftP[r]) % Cols]];
      end
    end
    for (int c = 0; c < Cols; c++) begin
      for (int r = 0; r < Rows; r++) begin
        acc = 8'h00;
        for (int j = 0; j < Rows; j++) begin
          acc ^= gf_mul(t[j][c], MixCoef[(j + Rows - r) % Rows]);
        end
        o[r][c] = acc;
      end
    end
    return o;
  endfunction

endpackage

[rtl/grs512_round.sv]
// One registered Groestl round stage with valid/stall flow control.
module grs512_round #(
  parameter bit IsQ = 1'b0,
  parameter int Rnd = 0
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  grs512_pkg::state_t  in_state,
  input  grs512_pkg::state_t  in_aux,
  output logic                out_valid,
  input  logic                out_stall,
  output grs512_pkg::state_t  out_state,
  output grs512_pkg::state_t  out_aux
);
  logic valid;

  assign in_stall = valid && out_stall;
  assign out_valid = valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (!in_stall) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      out_state <= grs512_pkg::round_f(in_state, IsQ, 4'(Rnd));
      out_aux <= in_aux;
    end
  end
endmodule

[rtl/grs512_perm.sv]
// Fourteen-stage pipelined Groestl permutation, P or Q.
module grs512_perm #(
  parameter bit IsQ = 1'b0
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  grs512_pkg::state_t  in_state,
  input  grs512_pkg::state_t  in_aux,
  output logic                out_valid,
  input  logic                out_stall,
  output grs512_pkg::state_t  out_state,
  output grs512_pkg::state_t  out_aux
);
  localparam int N = grs512_pkg::Rounds;

  logic               v [N+1];
  logic               st [N+1];
  grs512_pkg::state_t s [N+1];
  grs512_pkg::state_t x [N+1];

  assign v[0] = in_valid;
  assign s[0] = in_state;
  assign x[0] = in_aux;
  assign in_stall = st[0];
  assign st[N] = out_stall;

  for (genvar i = 0; i < N; i++) begin : g_rnd
    grs512_round #(.IsQ(IsQ), .Rnd(i)) u_round (
      .clk(clk), .rst(rst),
      .in_valid(v[i]), .in_stall(st[i]), .in_state(s[i]), .in_aux(x[i]),
      .out_valid(v[i+1]), .out_stall(st[i+1]), .out_state(s[i+1]), .out_aux(x[i+1])
    );
  end

  assign out_valid = v[N];
  assign out_state = s[N];
  assign out_aux = x[N];
endmodule

[rtl/groestl512_single_block_hash.sv]
// Groestl-512 single-block hash top level.
// Usage: present a 64-byte message as message_word_0..7 with in_valid; it is
// taken as a beat at a rising edge where in_valid is high and in_stall low.
// The digest leaves on hash_word_0..7 with out_valid, taken as a beat where
// out_valid is high and out_stall low.
// Structure: 14 round stages run P and Q side by side, then 14 more
// stages run the output P permutation.
// Throughput: one message per cycle while in_stall is low; each round unit is
// its own register stage, so a new beat can enter every cycle unless stalled.
// Reset: rst (synchronous, active high) clears all stage valid bits; no
// message is in flight afterward.
// Stall: out_stall holds the last stage; the hold ripples back stage by
// stage only where a stage is full, so bubbles are squeezed and no beat is
// lost or repeated. A stalled output keeps its payload.
module groestl512_single_block_hash (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] message_word_0,
  input  logic [63:0] message_word_1,
  input  logic [63:0] message_word_2,
  input  logic [63:0] message_word_3,
  input  logic [63:0] message_word_4,
  input  logic [63:0] message_word_5,
  input  logic [63:0] message_word_6,
  input  logic [63:0] message_word_7,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] hash_word_0,
  output logic [63:0] hash_word_1,
  output logic [63:0] hash_word_2,
  output logic [63:0] hash_word_3,
  output logic [63:0] hash_word_4,
  output logic [63:0] hash_word_5,
  output logic [63:0] hash_word_6,
  output logic [63:0] hash_word_7
);
  logic [63:0] mw [8];
  grs512_pkg::state_t m;
  grs512_pkg::state_t h_iv;
  grs512_pkg::state_t pa, pq, qa, qq, cv, fo, fa;
  logic p_stall, q_stall, p_valid, q_valid, mid_stall, f_valid;

  assign mw = '{message_word_0, message_word_1, message_word_2, message_word_3,
                message_word_4, message_word_5, message_word_6, message_word_7};

  always_comb begin
    m = '0;
    h_iv = '0;
    for (int c = 0; c < 8; c++) begin
      for (int r = 0; r < grs512_pkg::Rows; r++) m[r][c] = mw[c][63 - 8*r -: 8];
    end
    m[0][8] = 8'h80;
    m[grs512_pkg::Rows-1][grs512_pkg::Cols-1] = 8'h01;
    h_iv[6][15] = 8'h02;
  end

  assign in_stall = p_stall;

  grs512_perm #(.IsQ(1'b0)) u_p (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(p_stall),
    .in_state(m ^ h_iv), .in_aux(h_iv), .out_valid(p_valid), .out_stall(mid_stall),
    .out_state(pa), .out_aux(pq)
  );

  grs512_perm #(.IsQ(1'b1)) u_q (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(q_stall),
    .in_state(m), .in_aux(h_iv), .out_valid(q_valid), .out_stall(mid_stall),
    .out_state(qa), .out_aux(qq)
  );

  assign cv = pa ^ qa ^ pq;

  grs512_perm #(.IsQ(1'b0)) u_f (
    .clk(clk), .rst(rst), .in_valid(p_valid), .in_stall(mid_stall),
    .in_state(cv), .in_aux(cv), .out_valid(f_valid), .out_stall(out_stall),
    .out_state(fo), .out_aux(fa)
  );

  assign out_valid = f_valid;

  always_comb begin
    logic [63:0] w [8];
    for (int c = 0; c < 8; c++) begin
      for (int r = 0; r < grs512_pkg::Rows; r++) begin
        w[c][63 - 8*r -: 8] = fo[r][c+8] ^ fa[r][c+8];
      end
    end
    hash_word_0 = w[0];
    hash_word_1 = w[1];
    hash_word_2 = w[2];
    hash_word_3 = w[3];
    hash_word_4 = w[4];
    hash_word_5 = w[5];
    hash_word_6 = w[6];
    hash_word_7 = w[7];
  end

  a_pq_lockstep: assert property (@(posedge clk) disable iff (rst)
    p_valid == q_valid) else $error("P and Q pipelines out of step");
  a_stall_lockstep: assert property (@(posedge clk) disable iff (rst)
    p_stall == q_stall) else $error("P and Q stalls differ");
  a_aux_same: assert property (@(posedge clk) disable iff (rst)
    p_valid |-> pq == qq) else $error("IV copies differ");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable({hash_word_0, hash_word_1,
    hash_word_2, hash_word_3, hash_word_4, hash_word_5, hash_word_6, hash_word_7}))
    else $error("stalled digest beat changed");
endmodule
